FILE: rtl/core/fvts_pkg.sv
// ----------------------------------------------------------------------------
// fvts_pkg
// types and constants shared by the tone sequencer modules
// ----------------------------------------------------------------------------
package fvts_pkg;

  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_PLAYING = 2'd1;
  localparam logic [1:0] MODE_PAUSED  = 2'd2;

  localparam logic [0:0] REQ_TICK = 1'b0;
  localparam logic [0:0] REQ_LOAD = 1'b1;

  localparam logic CFG_SONG_LENGTH = 1'b0;
  localparam logic CFG_DEBOUNCE    = 1'b1;

  localparam logic [19:0] TONE_CLOCK_HZ = 20'd1000000;
  localparam int unsigned PERIOD_MAX    = 65536;
  localparam logic [15:0] RELOAD_RESET  = 16'd1000;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

  // controller to datapath commands
  typedef struct packed {
    logic tick;        // run tick bookkeeping and key rules
    logic fetch_rd;    // issue table read at next_event
    logic div_start;   // start divide for current voice
    logic [1:0] voice; // voice being programmed
    logic voice_wr;    // write result of divide for voice
    logic fetch_end;   // finish fetch, load delay
    logic finish;      // apply not-playing mask
  } fvts_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_fetch;  // playing with zero delay and event in range
    logic div_done;
  } fvts_sts_t;

endpackage

FILE: rtl/core/fvts_div.sv
// ----------------------------------------------------------------------------
// fvts_div
// radix-2 restoring divider, 1000000 / freq, one quotient bit a cycle
// ----------------------------------------------------------------------------
module fvts_div import fvts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [19:0] quotient
);

  logic [19:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      quo_nxt  = TONE_CLOCK_HZ;
      rem_nxt  = '0;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, quo_r[19]};
      if (trial >= {1'b0, divisor}) begin
        // remainder stays below the divisor, so 16 bits hold it
        rem_nxt = 16'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[18:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[18:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd19) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/fvts_ctrl.sv
// ----------------------------------------------------------------------------
// fvts_ctrl
// sequencer for one item: tick rules, event fetch, four divides, result (a load goes straight to the result)
// ----------------------------------------------------------------------------
module fvts_ctrl import fvts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      is_tick,
  input  logic      out_fire,
  input  fvts_sts_t sts,
  output fvts_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_TICK  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_DIVGO = 7'b0001000,
    ST_DIVW  = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  voice_r, voice_nxt;

  always_comb begin
    state_nxt = state_r;
    voice_nxt = voice_r;
    cmd       = '0;
    cmd.voice = voice_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = is_tick ? ST_TICK : ST_OUT;
      end
      ST_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (sts.need_fetch) begin
          cmd.fetch_rd = 1'b1;
          voice_nxt    = 2'd0;
          state_nxt    = ST_DIVGO;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts.div_done) begin
          cmd.voice_wr = 1'b1;
          voice_nxt    = voice_r + 2'd1;
          if (voice_r == 2'd3) begin
            cmd.fetch_end = 1'b1;
            state_nxt     = ST_FIN;
          end else begin
            state_nxt = ST_DIVGO;
          end
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      voice_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      voice_r <= voice_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

`ifndef SYNTHESIS
  a_voice_wr_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.voice_wr |-> state_r == ST_DIVW) else $error("voice write outside divide");
  a_fetch_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch_rd |-> $past(cmd.tick)) else $error("fetch not after tick");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fire) |=> out_valid) else $error("result dropped");
`endif

endmodule

FILE: rtl/core/fvts_dp.sv
// ----------------------------------------------------------------------------
// fvts_dp
// player state, song table, key rules and voice programming
// ----------------------------------------------------------------------------
module fvts_dp import fvts_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fvts_cmd_t   cmd,
  output fvts_sts_t   sts,
  input  logic        load_we,
  input  logic [7:0]  load_index,
  input  logic [63:0] load_tones,
  input  logic [15:0] load_delay,
  input  logic        key_start,
  input  logic        key_pause,
  input  logic [8:0]  song_length,
  input  logic [15:0] debounce_ms,
  output logic [63:0] reload_q,
  output logic [63:0] compare_q,
  output logic [3:0]  voice_on,
  output logic [1:0]  player_mode,
  output logic [31:0] played_ms,
  output logic [8:0]  song_pos
);

  logic [63:0] tone_mem [TABLE_DEPTH];
  logic [15:0] dur_mem  [TABLE_DEPTH];
  logic [63:0] tone_rd_r;
  logic [15:0] dur_rd_r;

  logic [31:0] tick_r, elapsed_r, st_time_r, ps_time_r;
  logic [15:0] delay_r;
  logic [8:0]  next_r;
  logic [1:0]  mode_r;
  logic        st_arm_r, ps_arm_r;
  logic [15:0] reload_r [4];
  logic [15:0] cmp_r [4];
  logic [3:0]  en_r;

  logic [31:0] tick_nxt, elapsed_nxt;
  logic [15:0] delay_nxt;
  logic [8:0]  next_nxt;
  logic [1:0]  mode_nxt;
  logic        st_hit, ps_hit;

  logic [15:0] freq_cur;
  logic [19:0] quo;
  logic        div_done;
  logic [16:0] period;
  logic [15:0] cmp_val;
  logic [8:0]  limit;

  localparam logic [8:0] DEPTH_LIM = (TABLE_DEPTH > 256) ? 9'd256 : 9'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (load_we && (32'(load_index) < TABLE_DEPTH)) begin
      tone_mem[load_index[IDX_W-1:0]] <= load_tones;
      dur_mem[load_index[IDX_W-1:0]]  <= load_delay;
    end
    if (cmd.fetch_rd) begin
      tone_rd_r <= tone_mem[next_r[IDX_W-1:0]];
      dur_rd_r  <= dur_mem[next_r[IDX_W-1:0]];
    end
  end

  assign freq_cur = tone_rd_r[16*cmd.voice +: 16];

  fvts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .divisor(freq_cur),
    .done(div_done), .quotient(quo)
  );

  always_comb begin
    if (quo < 20'd2) period = 17'd2;
    else if (quo > 20'(PERIOD_MAX)) period = 17'(PERIOD_MAX);
    else period = quo[16:0];
    cmp_val = period[16:1];
  end

  assign limit = (song_length < DEPTH_LIM) ? song_length : DEPTH_LIM;

  // tick rules, all in one step
  always_comb begin
    tick_nxt    = tick_r + 32'd1;
    elapsed_nxt = elapsed_r;
    delay_nxt   = delay_r;
    next_nxt    = next_r;
    mode_nxt    = mode_r;
    if (mode_r == MODE_PLAYING) begin
      if (delay_r != 16'd0) delay_nxt = delay_r - 16'd1;
      elapsed_nxt = elapsed_r + 32'd1;
    end
    st_hit = key_start && st_arm_r && ((tick_nxt - st_time_r) > {16'd0, debounce_ms});
    ps_hit = key_pause && ps_arm_r && ((tick_nxt - ps_time_r) > {16'd0, debounce_ms});
    if (st_hit) begin
      if (mode_r == MODE_STOPPED) begin
        mode_nxt  = MODE_PLAYING;
        delay_nxt = 16'd1;
      end else begin
        mode_nxt = MODE_STOPPED;
      end
      next_nxt    = '0;
      elapsed_nxt = '0;
    end
    if (ps_hit) begin
      if (mode_nxt == MODE_PLAYING) mode_nxt = MODE_PAUSED;
      else if (mode_nxt == MODE_PAUSED) mode_nxt = MODE_PLAYING;
    end
  end

  assign sts.need_fetch = (mode_r == MODE_PLAYING) && (delay_r == 16'd0) && (next_r < limit);
  assign sts.div_done   = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      elapsed_r <= '0;
      delay_r   <= '0;
      next_r    <= '0;
      mode_r    <= MODE_STOPPED;
      st_arm_r  <= 1'b1;
      ps_arm_r  <= 1'b1;
      st_time_r <= '0;
      ps_time_r <= '0;
      en_r      <= '0;
      for (int i = 0; i < 4; i++) begin
        reload_r[i] <= RELOAD_RESET;
        cmp_r[i]    <= '0;
      end
    end else if (cmd.tick) begin
      tick_r    <= tick_nxt;
      elapsed_r <= elapsed_nxt;
      delay_r   <= delay_nxt;
      next_r    <= next_nxt;
      mode_r    <= mode_nxt;
      if (st_hit) begin
        st_time_r <= tick_nxt;
        st_arm_r  <= 1'b0;
      end else if (!key_start) begin
        st_arm_r <= 1'b1;
      end
      if (ps_hit) begin
        ps_time_r <= tick_nxt;
        ps_arm_r  <= 1'b0;
      end else if (!key_pause) begin
        ps_arm_r <= 1'b1;
      end
    end else if (cmd.voice_wr) begin
      if (freq_cur == 16'd0) begin
        en_r[cmd.voice] <= 1'b0;
      end else begin
        reload_r[cmd.voice] <= 16'(period - 17'd1);
        cmp_r[cmd.voice]    <= cmp_val;
        en_r[cmd.voice]     <= 1'b1;
      end
      if (cmd.fetch_end) begin
        delay_r <= (dur_rd_r == 16'd0) ? 16'd1 : dur_rd_r;
        next_r  <= next_r + 9'd1;
      end
    end else if (cmd.finish) begin
      // end of song: playing, zero delay and no event left
      if (mode_r == MODE_PLAYING && delay_r == 16'd0 && next_r >= limit) begin
        mode_r    <= MODE_STOPPED;
        next_r    <= '0;
        elapsed_r <= '0;
        en_r      <= '0;
      end else if (mode_r != MODE_PLAYING) begin
        en_r <= '0;
      end
    end
  end

  assign reload_q    = {reload_r[3], reload_r[2], reload_r[1], reload_r[0]};
  assign compare_q   = {cmp_r[3], cmp_r[2], cmp_r[1], cmp_r[0]};
  assign voice_on    = en_r;
  assign player_mode = mode_r;
  assign played_ms   = elapsed_r;
  assign song_pos    = next_r;

`ifndef SYNTHESIS
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != 2'd3) else $error("bad mode");
  a_silent_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.finish) && mode_r != MODE_PLAYING |-> en_r == 4'd0)
    else $error("voice on while not playing");
  a_delay_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.fetch_end) |-> delay_r != 16'd0) else $error("zero delay after fetch");
`endif

endmodule

FILE: rtl/core/four_voice_tone_sequencer_top.sv
// ----------------------------------------------------------------------------
// four_voice_tone_sequencer_top
// four-voice song player stepped by 1 ms tick beats
// ----------------------------------------------------------------------------
// Each input beat is either a load (writes one song event) or a 1 ms tick
// carrying the start/stop and pause/play key levels; every beat gives one
// result beat with the four voice settings and player status. One beat is
// handled at a time; the next beat is accepted only after the result is
// taken. A tick that fetches an event runs four divides of 1000000 by each
// voice frequency on one shared divider (per voice: start, 20 quotient
// bits, write).
// The song table is a 1-write 1-read memory with no clearing pass.
module four_voice_tone_sequencer_top import fvts_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tuser: req_type
  input  logic [0:0]   in_tuser,
  // tdata: key_start, key_pause, entry_index, tone_a, tone_b, tone_c, tone_d,
  // entry_delay (from bit 0 up), zero fill to 96 bits
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: reload_a..d, compare_a..d, voice_on, player_mode, played_ms,
  // song_pos (from bit 0 up), zero fill to 184 bits
  output logic [183:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // entry_index is 8 bits wide, so at most 256 entries are addressable
  localparam int IDX_W = (TABLE_DEPTH > 256) ? 8 :
                         ((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1);

  fvts_cmd_t cmd;
  fvts_sts_t sts;
  logic      busy, in_fire, out_fire;
  logic [8:0]  song_len_r;
  logic [15:0] debounce_r;
  logic [63:0] reload_q, compare_q;
  logic [3:0]  voice_on;
  logic [1:0]  player_mode;
  logic [31:0] played_ms;
  logic [8:0]  song_pos;
  logic        key_start_r, key_pause_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_len_r <= '0;
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SONG_LENGTH) song_len_r <= cfg_data[8:0];
      else debounce_r <= cfg_data;
    end
  end

  // key levels held for the tick step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_start_r <= in_tdata[0];
      key_pause_r <= in_tdata[1];
    end
  end

  fvts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .is_tick(in_tuser == REQ_TICK),
    .out_fire(out_fire), .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_tvalid)
  );

  fvts_dp #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .load_we(in_fire && in_tuser == REQ_LOAD),
    .load_index(in_tdata[9:2]),
    .load_tones(in_tdata[73:10]),
    .load_delay(in_tdata[89:74]),
    .key_start(key_start_r), .key_pause(key_pause_r),
    .song_length(song_len_r), .debounce_ms(debounce_r),
    .reload_q(reload_q), .compare_q(compare_q), .voice_on(voice_on),
    .player_mode(player_mode), .played_ms(played_ms), .song_pos(song_pos)
  );

  assign out_tdata = {9'd0, song_pos, played_ms, player_mode, voice_on, compare_q, reload_q};

endmodule
